// ===== rtl/core/pgs_pkg.sv =====
package pgs_pkg;

  // Grid geometry.
  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 64;
  localparam int CELL_COUNT  = 4096;

  localparam int PLANE_CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int STORE_DEPTH = (PLANE_CELLS > CELL_COUNT) ? PLANE_CELLS : CELL_COUNT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

  localparam int LEVEL_W = 16;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SENSE_FLOOR   = 2'd0;
  localparam logic [1:0] CFG_INTENSITY_MAX = 2'd1;
  localparam logic [1:0] CFG_DECAY_FACTOR  = 2'd2;

  localparam logic [LEVEL_W-1:0] SENSE_FLOOR_RST   = 16'd26;
  localparam logic [LEVEL_W-1:0] INTENSITY_MAX_RST = 16'd65535;
  localparam logic [LEVEL_W-1:0] DECAY_FACTOR_RST  = 16'd62259;

  typedef enum logic [1:0] {
    OP_SENSE   = 2'd0,
    OP_RAW     = 2'd1,
    OP_DEPOSIT = 2'd2,
    OP_DECAY   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_SWEEP,
    ST_HOLD
  } state_t;

endpackage

// ===== rtl/core/pgs_ram.sv =====
module pgs_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/pheromone_grid_store.sv =====
// Reads and deposits are accepted in idle and finish in the access state with the single
// read-modify-write pass through the cell memory; the next word waits until idle again.
// A decay tick sweeps CELL_COUNT cells of both layers in parallel with one memory read per
// cycle, and the multiply and write-back stages then drain before the sweep finishes.
// After reset a clearing pass zeroes STORE_DEPTH (4096) cells per layer, one per cycle,
// and no word is accepted until it ends; configuration writes are taken throughout.
module pheromone_grid_store (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [pgs_pkg::LEVEL_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  op,
  input  logic                        layer,
  input  logic signed [7:0]           col,
  input  logic signed [7:0]           row,
  input  logic [pgs_pkg::LEVEL_W-1:0] amount,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pgs_pkg::LEVEL_W-1:0] level,
  output logic                        on_grid
);

  import pgs_pkg::*;

  localparam logic [7:0] COL_LIM = 8'(GRID_WIDTH);
  localparam logic [7:0] ROW_LIM = 8'(GRID_HEIGHT);

  // Configuration registers.
  logic [LEVEL_W-1:0] floor_level;
  logic [LEVEL_W-1:0] intensity_max;
  logic [LEVEL_W-1:0] decay_factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_level   <= SENSE_FLOOR_RST;
      intensity_max <= INTENSITY_MAX_RST;
      decay_factor  <= DECAY_FACTOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SENSE_FLOOR:   floor_level   <= cfg_wdata;
        CFG_INTENSITY_MAX: intensity_max <= cfg_wdata;
        CFG_DECAY_FACTOR:  decay_factor  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  state_t state, state_next;

  // Shared counter: clearing pass address after reset, sweep read address during decay.
  logic [CNT_W-1:0] cnt;

  // Decode of the incoming word's coordinates into a store address.
  logic              in_inside;
  logic [ADDR_W-1:0] in_addr;

  assign in_inside = !col[7] && !row[7] && ({1'b0, col[6:0]} < COL_LIM)
                     && ({1'b0, row[6:0]} < ROW_LIM);
  assign in_addr = ADDR_W'(int'(row[6:0]) * GRID_WIDTH + int'(col[6:0]));

  // Captured word for the read-modify-write pass.
  op_t               op_q;
  logic              layer_q;
  logic              inside_q;
  logic [ADDR_W-1:0] addr_q;
  logic [LEVEL_W-1:0] amount_q;

  logic accept;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= op_t'(op);
      layer_q  <= layer;
      inside_q <= in_inside;
      addr_q   <= in_addr;
      amount_q <= amount;
    end
  end

  // Cell memories, one per layer.
  logic              home_we, food_we;
  logic [ADDR_W-1:0] home_waddr, food_waddr;
  logic [LEVEL_W-1:0] home_wdata, food_wdata;
  logic [ADDR_W-1:0] raddr;
  logic [LEVEL_W-1:0] home_rdata, food_rdata;

  pgs_ram #(.DEPTH(STORE_DEPTH), .WIDTH(LEVEL_W)) u_home_ram (
    .clk   (clk),
    .we    (home_we),
    .waddr (home_waddr),
    .wdata (home_wdata),
    .raddr (raddr),
    .rdata (home_rdata)
  );

  pgs_ram #(.DEPTH(STORE_DEPTH), .WIDTH(LEVEL_W)) u_food_ram (
    .clk   (clk),
    .we    (food_we),
    .waddr (food_waddr),
    .wdata (food_wdata),
    .raddr (raddr),
    .rdata (food_rdata)
  );

  // Decay sweep pipeline: the read is issued with cnt, stage 1 holds the read data
  // going into the multiplier, stage 2 holds the products for the floor test and write.
  logic              sweep_issue;
  logic              s1_valid, s2_valid;
  logic [ADDR_W-1:0] s1_addr, s2_addr;
  logic [2*LEVEL_W-1:0] home_prod, food_prod;
  logic [LEVEL_W-1:0] home_scaled, food_scaled;
  logic [LEVEL_W-1:0] home_decayed, food_decayed;
  logic              sweep_done;

  assign sweep_issue = (state == ST_SWEEP) && (cnt < CNT_W'(CELL_COUNT));
  assign sweep_done  = (state == ST_SWEEP) && !sweep_issue && !s1_valid && !s2_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= sweep_issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr   <= cnt[ADDR_W-1:0];
    s2_addr   <= s1_addr;
    home_prod <= home_rdata * decay_factor;
    food_prod <= food_rdata * decay_factor;
  end

  // A zero cell gives a zero product, which never exceeds the floor, so it stays zero.
  assign home_scaled  = home_prod[2*LEVEL_W-1:LEVEL_W];
  assign food_scaled  = food_prod[2*LEVEL_W-1:LEVEL_W];
  assign home_decayed = (home_scaled > floor_level) ? home_scaled : '0;
  assign food_decayed = (food_scaled > floor_level) ? food_scaled : '0;

  // Read-modify-write of one cell in the access cycle, when the read data has arrived.
  logic [LEVEL_W-1:0] cell_old;
  logic [LEVEL_W-1:0] dep_larger;
  logic [LEVEL_W-1:0] dep_value;
  logic              dep_write;

  assign cell_old   = layer_q ? food_rdata : home_rdata;
  assign dep_larger = (amount_q > cell_old) ? amount_q : cell_old;
  assign dep_value  = (dep_larger > intensity_max) ? intensity_max : dep_larger;
  assign dep_write  = (state == ST_ACCESS) && (op_q == OP_DEPOSIT) && inside_q;

  // Result of the finishing word, from an access or the end of a sweep.
  logic              res_done;
  logic [LEVEL_W-1:0] res_level;
  logic              res_on_grid;
  logic              out_free;

  assign out_free = !out_valid || out_ready;
  assign res_done = (state == ST_ACCESS) || sweep_done;

  always_comb begin
    res_level   = '0;
    res_on_grid = 1'b0;
    if (state == ST_ACCESS) begin
      res_on_grid = inside_q;
      if (inside_q) begin
        case (op_q)
          OP_SENSE: res_level = (cell_old > floor_level) ? cell_old : '0;
          OP_RAW:   res_level = cell_old;
          default:  res_level = '0;
        endcase
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (cnt == CNT_W'(STORE_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (op_t'(op) == OP_DECAY) ? ST_SWEEP : ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        state_next = out_free ? ST_IDLE : ST_HOLD;
      end
      ST_SWEEP: begin
        if (sweep_done) begin
          state_next = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Outputs of the state machine: handshake, memory ports.
  always_comb begin
    in_ready   = 1'b0;
    raddr      = in_addr;
    home_we    = 1'b0;
    food_we    = 1'b0;
    home_waddr = addr_q;
    food_waddr = addr_q;
    home_wdata = dep_value;
    food_wdata = dep_value;
    case (state)
      ST_CLEAR: begin
        home_we    = 1'b1;
        food_we    = 1'b1;
        home_waddr = cnt[ADDR_W-1:0];
        food_waddr = cnt[ADDR_W-1:0];
        home_wdata = '0;
        food_wdata = '0;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_ACCESS: begin
        home_we = dep_write && !layer_q;
        food_we = dep_write && layer_q;
      end
      ST_SWEEP: begin
        raddr      = cnt[ADDR_W-1:0];
        home_we    = s2_valid;
        food_we    = s2_valid;
        home_waddr = s2_addr;
        food_waddr = s2_addr;
        home_wdata = home_decayed;
        food_wdata = food_decayed;
      end
      default: ;
    endcase
  end

  // Counter: steps through the clearing pass and the sweep, and returns to zero after each.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == ST_CLEAR) begin
      cnt <= (cnt == CNT_W'(STORE_DEPTH - 1)) ? '0 : cnt + 1'b1;
    end else if (sweep_issue) begin
      cnt <= cnt + 1'b1;
    end else if (sweep_done) begin
      cnt <= '0;
    end
  end

  // A finished result waits in the pending register while the output register is still
  // occupied, so the memory read data can be dropped.
  logic [LEVEL_W-1:0] pend_level;
  logic              pend_on_grid;

  always_ff @(posedge clk) begin
    if (res_done) begin
      pend_level   <= res_level;
      pend_on_grid <= res_on_grid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_done && out_free) begin
      out_valid <= 1'b1;
    end else if ((state == ST_HOLD) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_done && out_free) begin
      level   <= res_level;
      on_grid <= res_on_grid;
    end else if ((state == ST_HOLD) && out_free) begin
      level   <= pend_level;
      on_grid <= pend_on_grid;
    end
  end

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("accepted word did not start an access or sweep");

  a_single_layer_deposit: assert property (@(posedge clk) disable iff (rst)
    state == ST_ACCESS |-> $onehot0({home_we, food_we}))
    else $error("deposit wrote both layers");

  a_sweep_pipe_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (s1_valid || s2_valid) |-> state == ST_SWEEP)
    else $error("sweep pipeline active outside a sweep");

  a_hold_has_output: assert property (@(posedge clk) disable iff (rst)
    state == ST_HOLD |-> out_valid)
    else $error("pending result without an occupied output register");

  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SWEEP |-> cnt <= CNT_W'(CELL_COUNT))
    else $error("sweep counter ran past the cell count");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

// Testbench for the pheromone grid store.
//
// The sender drives one word per operation (sensed read, raw read, deposit
// or decay tick) over a valid/ready channel, and the receiver takes one
// result word per operation over a second valid/ready channel. Both sides
// insert random gaps, mostly short and now and then long. Some phases run
// with no gaps at all so the block is also exercised at full rate.
//
// A predictor inside this module keeps its own copy of both grid layers and
// of the three configuration registers. It works out each expected result
// when the word is accepted. A separate process compares every result word,
// field by field, with the oldest expected one.
module tb_top;
  import pgs_pkg::*;

  // Register index that maps to no register; writes to it must be ignored.
  localparam logic [1:0] CFG_SPARE = 2'd3;

  // Number of result mismatches that get printed in full.
  localparam int SHOWN_ERRORS = 10;

  // Words sent by the random traffic phases, about 1850 in total.
  localparam int PHASE_WORDS = 232;

  // One result word as the block returns it.
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               on_grid;
  } grid_result_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_we = 1'b0;
  logic [1:0]                  cfg_index = CFG_SENSE_FLOOR;
  logic [LEVEL_W-1:0]          cfg_wdata = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [1:0]                  op = OP_SENSE;
  logic                        layer = 1'b0;
  logic signed [7:0]           col = '0;
  logic signed [7:0]           row = '0;
  logic [LEVEL_W-1:0]          amount = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [LEVEL_W-1:0]          level;
  logic                        on_grid;

  // Predicted contents of both layers (index 0 is home, 1 is food) and the
  // predicted register values.
  logic [LEVEL_W-1:0] model_levels [2][STORE_DEPTH];
  logic [LEVEL_W-1:0] floor_reg;
  logic [LEVEL_W-1:0] ceiling_reg;
  logic [LEVEL_W-1:0] decay_reg;

  // Results that have been predicted but not yet seen, oldest first.
  grid_result_t expected_levels [$];

  int  err_count = 0;
  int  stall_left = 0;
  // When set, neither side inserts any gaps.
  bit  no_gaps = 1'b0;

  pheromone_grid_store u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .layer     (layer),
    .col       (col),
    .row       (row),
    .amount    (amount),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .level     (level),
    .on_grid   (on_grid)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Generous limit. The slowest correct run is roughly the clearing pass, a
  // few dozen decay sweeps over the whole grid, and every word paying the
  // longest sender gap plus the longest receiver stall.
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Counts a failure and tells the caller whether it should still be shown.
  function automatic bit log_error();
    err_count++;
    return err_count <= SHOWN_ERRORS;
  endfunction

  // Gap length in cycles: half of the time none, mostly a few, rarely long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Predicted cell value after one decay tick.
  function automatic logic [LEVEL_W-1:0] decayed_level(input logic [LEVEL_W-1:0] v);
    logic [31:0] prod;
    if (v == '0) return '0;
    prod = (32'(v) * 32'(decay_reg)) >> 16;
    return (prod > 32'(floor_reg)) ? prod[LEVEL_W-1:0] : '0;
  endfunction

  // Applies one word to the predicted grids and returns the result it yields.
  function automatic void predict_grid_word(input op_t kind, input logic lyr,
                                            input logic signed [7:0] c,
                                            input logic signed [7:0] r,
                                            input logic [LEVEL_W-1:0] amt,
                                            output grid_result_t res);
    int                 addr;
    bit                 on_map;
    logic [LEVEL_W-1:0] v;
    res = '0;
    if (kind == OP_DECAY) begin
      // The sweep touches every cell of both layers; coordinates are ignored.
      for (int l = 0; l < 2; l++) begin
        for (int i = 0; i < CELL_COUNT; i++) begin
          model_levels[l][i] = decayed_level(model_levels[l][i]);
        end
      end
      return;
    end
    on_map = c >= 0 && c < GRID_WIDTH && r >= 0 && r < GRID_HEIGHT;
    res.on_grid = on_map;
    if (!on_map) return;
    addr = int'(r) * GRID_WIDTH + int'(c);
    v = model_levels[lyr][addr];
    case (kind)
      OP_SENSE: res.level = (v > floor_reg) ? v : '0;
      OP_RAW:   res.level = v;
      default: begin
        if (amt > v) v = amt;
        if (v > ceiling_reg) v = ceiling_reg;
        model_levels[lyr][addr] = v;
      end
    endcase
  endfunction

  // Writes one configuration register and mirrors it in the predictor.
  task automatic cfg_write(input logic [1:0] idx, input logic [LEVEL_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SENSE_FLOOR:   floor_reg   = data;
      CFG_INTENSITY_MAX: ceiling_reg = data;
      CFG_DECAY_FACTOR:  decay_reg   = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic cfg_write_all(input logic [LEVEL_W-1:0] floor_v,
                               input logic [LEVEL_W-1:0] ceiling_v,
                               input logic [LEVEL_W-1:0] decay_v);
    cfg_write(CFG_SENSE_FLOOR, floor_v);
    cfg_write(CFG_INTENSITY_MAX, ceiling_v);
    cfg_write(CFG_DECAY_FACTOR, decay_v);
  endtask

  // Sends one word after a random gap and records its predicted result at
  // the edge where it is accepted. Valid stays high across back-to-back
  // words, so it is only lowered when a gap follows.
  task automatic send_word(input op_t kind, input logic lyr,
                           input logic signed [7:0] c, input logic signed [7:0] r,
                           input logic [LEVEL_W-1:0] amt);
    int           gap;
    grid_result_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= kind;
    layer    <= lyr;
    col      <= c;
    row      <= r;
    amount   <= amt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_grid_word(kind, lyr, c, r, amt, predicted);
    expected_levels.push_back(predicted);
  endtask

  // Stops sending and waits until every predicted result has come back.
  // Every word yields exactly one result, so an empty queue means the block
  // is idle; a few extra cycles are added anyway.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Coordinate for random traffic. Most land near the grid edges so that
  // reads find cells that earlier deposits filled; some go anywhere on the
  // grid and some take any byte value, which is mostly off grid.
  function automatic logic signed [7:0] pick_coord(input int extent);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      if ($urandom_range(0, 1)) return 8'($urandom_range(0, 3));
      return 8'(extent - 1 - $urandom_range(0, 3));
    end
    if (roll < 85) return 8'($urandom_range(0, extent - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_random_word();
    int                 roll;
    op_t                kind;
    logic [LEVEL_W-1:0] amt;
    roll = $urandom_range(0, 999);
    // Decay ticks are kept rare because each one sweeps the whole grid.
    if (roll < 25)       kind = OP_DECAY;
    else if (roll < 390) kind = OP_DEPOSIT;
    else if (roll < 700) kind = OP_SENSE;
    else                 kind = OP_RAW;
    if ($urandom_range(0, 9) < 7) amt = LEVEL_W'($urandom_range(0, 65535));
    else amt = LEVEL_W'($urandom_range(0, 64));
    send_word(kind, 1'($urandom_range(0, 1)), pick_coord(GRID_WIDTH),
              pick_coord(GRID_HEIGHT), amt);
  endtask

  // Cells must read as zero once the clearing pass after reset is done; three cells are sampled.
  task automatic test_cleared_grid();
    send_word(OP_RAW, 1'b0, 8'sd0, 8'sd0, '0);
    send_word(OP_RAW, 1'b1, 8'sd63, 8'sd63, '0);
    send_word(OP_SENSE, 1'b1, 8'sd17, 8'sd40, 16'hFFFF);
  endtask

  // Deposits keep the larger level and are clamped to the ceiling; sensed
  // reads hide levels at or below the floor.
  task automatic test_deposit_and_read();
    drain();
    cfg_write(CFG_INTENSITY_MAX, 16'h8000);
    send_word(OP_DEPOSIT, 1'b0, 8'sd0, 8'sd0, 16'hFFFF);
    send_word(OP_DEPOSIT, 1'b1, 8'sd63, 8'sd63, 16'h0001);
    send_word(OP_DEPOSIT, 1'b0, 8'sd0, 8'sd0, 16'h0100);
    send_word(OP_DEPOSIT, 1'b1, 8'sd63, 8'sd0, 16'h0000);
    send_word(OP_RAW, 1'b0, 8'sd0, 8'sd0, '0);
    send_word(OP_SENSE, 1'b0, 8'sd0, 8'sd0, '0);
    send_word(OP_SENSE, 1'b1, 8'sd63, 8'sd63, '0);
    send_word(OP_RAW, 1'b1, 8'sd63, 8'sd63, '0);
    drain();
    cfg_write(CFG_INTENSITY_MAX, INTENSITY_MAX_RST);
  endtask

  // Coordinates off the grid read as zero with on_grid low, and deposits
  // there change nothing.
  task automatic test_off_grid();
    send_word(OP_DEPOSIT, 1'b0, -8'sd1, 8'sd0, 16'hAAAA);
    send_word(OP_DEPOSIT, 1'b1, 8'sd64, 8'sd5, 16'h5555);
    send_word(OP_DEPOSIT, 1'b0, 8'sd5, 8'sd64, 16'hAAAA);
    send_word(OP_DEPOSIT, 1'b1, -8'sd128, 8'sd127, 16'h5555);
    send_word(OP_RAW, 1'b0, -8'sd1, 8'sd0, '0);
    send_word(OP_RAW, 1'b1, 8'sd127, -8'sd128, '0);
    send_word(OP_SENSE, 1'b0, 8'sd0, -8'sd1, '0);
  endtask

  // A decay tick scales every cell, zeroes a cell that falls to the floor,
  // leaves zero cells at zero, and reports on_grid low whatever the
  // coordinates say.
  task automatic test_decay();
    send_word(OP_DEPOSIT, 1'b0, 8'sd1, 8'sd1, 16'h1000);
    send_word(OP_DEPOSIT, 1'b1, 8'sd2, 8'sd2, 16'd27);
    send_word(OP_DECAY, 1'b1, 8'sd1, 8'sd1, 16'hFFFF);
    send_word(OP_RAW, 1'b0, 8'sd1, 8'sd1, '0);
    send_word(OP_RAW, 1'b1, 8'sd2, 8'sd2, '0);
    send_word(OP_RAW, 1'b1, 8'sd3, 8'sd3, '0);
  endtask

  // Random traffic under one register setting.
  task automatic run_traffic_phase(input logic [LEVEL_W-1:0] floor_v,
                                   input logic [LEVEL_W-1:0] ceiling_v,
                                   input logic [LEVEL_W-1:0] decay_v,
                                   input bit gapless);
    drain();
    cfg_write_all(floor_v, ceiling_v, decay_v);
    // A write to the spare index must leave all registers as they are.
    cfg_write(CFG_SPARE, LEVEL_W'($urandom_range(0, 65535)));
    no_gaps = gapless;
    for (int n = 0; n < PHASE_WORDS; n++) send_random_word();
    no_gaps = 1'b0;
  endtask

  // Walks through several register settings, the extremes among them.
  task automatic test_random_traffic();
    run_traffic_phase(SENSE_FLOOR_RST, INTENSITY_MAX_RST, DECAY_FACTOR_RST, 1'b0);
    run_traffic_phase(16'h0000, 16'hFFFF, 16'hFFFF, 1'b0);
    run_traffic_phase(16'hFFFF, LEVEL_W'($urandom_range(0, 65535)), 16'h0000, 1'b0);
    run_traffic_phase(LEVEL_W'($urandom_range(0, 400)), 16'h0000, 16'h8000, 1'b0);
    run_traffic_phase(LEVEL_W'($urandom_range(0, 400)), 16'hFFFF,
                      LEVEL_W'($urandom_range(40000, 65535)), 1'b1);
    run_traffic_phase(LEVEL_W'($urandom_range(0, 65535)), LEVEL_W'($urandom_range(0, 65535)),
                      LEVEL_W'($urandom_range(0, 65535)), 1'b0);
    run_traffic_phase(LEVEL_W'($urandom_range(0, 100)), LEVEL_W'($urandom_range(0, 65535)),
                      LEVEL_W'($urandom_range(0, 65535)), 1'b1);
    run_traffic_phase(SENSE_FLOOR_RST, INTENSITY_MAX_RST, DECAY_FACTOR_RST, 1'b0);
  endtask

  // Receiver side: out_ready follows its own random stall pattern.
  always @(posedge clk) begin : result_stall
    int g;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      g = pick_gap();
      if (g > 0) begin
        stall_left <= g - 1;
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Every result word taken by the receiver is matched against the oldest
  // prediction. Values are sampled at the edge, before the block updates.
  always @(posedge clk) begin : result_check
    grid_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_levels.size() == 0) begin
        if (log_error())
          $display("%0t: result with nothing expected: level=%h on_grid=%b",
                   $time, level, on_grid);
      end else begin
        want = expected_levels.pop_front();
        if (level !== want.level) begin
          if (log_error())
            $display("%0t: level mismatch: expected %h, got %h", $time, want.level, level);
        end
        if (on_grid !== want.on_grid) begin
          if (log_error())
            $display("%0t: on_grid mismatch: expected %b, got %b",
                     $time, want.on_grid, on_grid);
        end
      end
    end
  end

  initial begin
    for (int l = 0; l < 2; l++) begin
      for (int i = 0; i < STORE_DEPTH; i++) model_levels[l][i] = '0;
    end
    floor_reg   = SENSE_FLOOR_RST;
    ceiling_reg = INTENSITY_MAX_RST;
    decay_reg   = DECAY_FACTOR_RST;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The clearing pass after reset holds off the first word; send_word
    // simply waits for in_ready.
    test_cleared_grid();
    test_deposit_and_read();
    test_off_grid();
    test_decay();
    test_random_traffic();

    // Let the last results come back, then watch for stray ones.
    drain();
    repeat (20) @(posedge clk);
    if (expected_levels.size() != 0) err_count++;
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
